FILE: design/twg_pkg.sv
// ----------------------------------------------------------------------------
// twg_pkg
// Shared types and constants of the trapezoid wave generator: segment
// codes, configuration register indexes and register reset values.
// ----------------------------------------------------------------------------
package twg_pkg;

  // Waveform segments, in period order
  typedef enum logic [1:0] {
    SEG_RISE = 2'd0,
    SEG_TOP  = 2'd1,
    SEG_FALL = 2'd2,
    SEG_LOW  = 2'd3
  } seg_t;

  // Configuration port
  localparam int CFG_ADDR_BITS = 3;

  typedef enum logic [CFG_ADDR_BITS-1:0] {
    REG_PEAK_LEVEL = 3'd0,
    REG_STEP_SIZE  = 3'd1,
    REG_RAMP_STEPS = 3'd2,
    REG_STEP_TICKS = 3'd3,
    REG_HOLD_TICKS = 3'd4
  } cfg_reg_t;

  // Register reset values (truncated to the configured widths)
  localparam int RST_PEAK_LEVEL = 4095;
  localparam int RST_STEP_SIZE  = 8;
  localparam int RST_RAMP_STEPS = 511;
  localparam int RST_STEP_TICKS = 500;
  localparam int RST_HOLD_TICKS = 1000;

endpackage

FILE: design/trapezoid_wave_generator.sv
// ----------------------------------------------------------------------------
// trapezoid_wave_generator
// Trapezoid waveform generator: one DAC level result per timebase tick.
// ----------------------------------------------------------------------------
// Pipeline: an accepted tick is held in the input register, then its result is
//   registered in the result register, from which it can leave.
// Throughput: one tick per cycle while the result side does not stall.
// Reset (rst_n, synchronous): registers return to their defaults, the period
//   restarts at the rising ramp and both pipeline stages empty.
module trapezoid_wave_generator #(
  parameter int LEVEL_BITS = 12,
  parameter int TIME_BITS  = 20
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_we,
  input  logic [twg_pkg::CFG_ADDR_BITS-1:0] cfg_addr,
  input  logic [((LEVEL_BITS > TIME_BITS) ? LEVEL_BITS : TIME_BITS)-1:0] cfg_wdata,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic                              in_restart,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [LEVEL_BITS-1:0]             out_level,
  output logic [1:0]                        out_segment,
  output logic                              out_period_start
);

  localparam int CFG_BITS = (LEVEL_BITS > TIME_BITS) ? LEVEL_BITS : TIME_BITS;

  logic [LEVEL_BITS-1:0] peak_level, step_size, ramp_steps;
  logic [TIME_BITS-1:0]  step_ticks, hold_ticks;

  logic                  s0_valid_r, s0_restart_r;
  logic                  s0_advance;
  logic [LEVEL_BITS-1:0] level;
  twg_pkg::seg_t         segment;
  logic                  period_start;

  logic                  out_valid_r;
  logic [LEVEL_BITS-1:0] out_level_r;
  logic [1:0]            out_segment_r;
  logic                  out_period_start_r;

  twg_cfg #(
    .LEVEL_BITS (LEVEL_BITS),
    .TIME_BITS  (TIME_BITS),
    .CFG_BITS   (CFG_BITS)
  ) u_cfg (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata),
    .peak_level (peak_level),
    .step_size  (step_size),
    .ramp_steps (ramp_steps),
    .step_ticks (step_ticks),
    .hold_ticks (hold_ticks)
  );

  // Move the held tick into the result register when that slot frees up
  assign s0_advance = s0_valid_r && (!out_valid_r || out_ready);
  assign in_ready   = !s0_valid_r || s0_advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_valid_r <= 1'b0;
    end else if (in_ready) begin
      s0_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s0_restart_r <= in_restart;
    end
  end

  twg_seq #(
    .LEVEL_BITS (LEVEL_BITS),
    .TIME_BITS  (TIME_BITS)
  ) u_seq (
    .clk          (clk),
    .rst_n        (rst_n),
    .advance      (s0_advance),
    .restart      (s0_restart_r),
    .peak_level   (peak_level),
    .step_size    (step_size),
    .ramp_steps   (ramp_steps),
    .step_ticks   (step_ticks),
    .hold_ticks   (hold_ticks),
    .level        (level),
    .segment      (segment),
    .period_start (period_start)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s0_advance) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s0_advance) begin
      out_level_r        <= level;
      out_segment_r      <= segment;
      out_period_start_r <= period_start;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_level        = out_level_r;
  assign out_segment      = out_segment_r;
  assign out_period_start = out_period_start_r;

endmodule

FILE: design/twg_cfg.sv
// ----------------------------------------------------------------------------
// twg_cfg
// Configuration register file: peak level, step size, ramp length and the
// step and hold durations, written through a plain indexed write port.
// ----------------------------------------------------------------------------
module twg_cfg #(
  parameter int LEVEL_BITS = 12,
  parameter int TIME_BITS  = 20,
  parameter int CFG_BITS   = 20
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_we,
  input  logic [twg_pkg::CFG_ADDR_BITS-1:0] cfg_addr,
  input  logic [CFG_BITS-1:0]               cfg_wdata,
  output logic [LEVEL_BITS-1:0]             peak_level,
  output logic [LEVEL_BITS-1:0]             step_size,
  output logic [LEVEL_BITS-1:0]             ramp_steps,
  output logic [TIME_BITS-1:0]              step_ticks,
  output logic [TIME_BITS-1:0]              hold_ticks
);

  logic [LEVEL_BITS-1:0] peak_level_r;
  logic [LEVEL_BITS-1:0] step_size_r;
  logic [LEVEL_BITS-1:0] ramp_steps_r;
  logic [TIME_BITS-1:0]  step_ticks_r;
  logic [TIME_BITS-1:0]  hold_ticks_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      peak_level_r <= LEVEL_BITS'(twg_pkg::RST_PEAK_LEVEL);
      step_size_r  <= LEVEL_BITS'(twg_pkg::RST_STEP_SIZE);
      ramp_steps_r <= LEVEL_BITS'(twg_pkg::RST_RAMP_STEPS);
      step_ticks_r <= TIME_BITS'(twg_pkg::RST_STEP_TICKS);
      hold_ticks_r <= TIME_BITS'(twg_pkg::RST_HOLD_TICKS);
    end else if (cfg_we) begin
      unique case (cfg_addr)
        twg_pkg::REG_PEAK_LEVEL: peak_level_r <= cfg_wdata[LEVEL_BITS-1:0];
        twg_pkg::REG_STEP_SIZE:  step_size_r  <= cfg_wdata[LEVEL_BITS-1:0];
        twg_pkg::REG_RAMP_STEPS: ramp_steps_r <= cfg_wdata[LEVEL_BITS-1:0];
        twg_pkg::REG_STEP_TICKS: step_ticks_r <= cfg_wdata[TIME_BITS-1:0];
        twg_pkg::REG_HOLD_TICKS: hold_ticks_r <= cfg_wdata[TIME_BITS-1:0];
        default: ;  // drop writes to unmapped indexes
      endcase
    end
  end

  assign peak_level = peak_level_r;
  assign step_size  = step_size_r;
  assign ramp_steps = ramp_steps_r;
  assign step_ticks = step_ticks_r;
  assign hold_ticks = hold_ticks_r;

endmodule

FILE: design/twg_seq.sv
// ----------------------------------------------------------------------------
// twg_seq
// Segment sequencer: holds segment, ramp index and tick count, forms the
// level of the current tick and advances the state once per processed tick.
// ----------------------------------------------------------------------------
module twg_seq #(
  parameter int LEVEL_BITS = 12,
  parameter int TIME_BITS  = 20
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  advance,
  input  logic                  restart,
  input  logic [LEVEL_BITS-1:0] peak_level,
  input  logic [LEVEL_BITS-1:0] step_size,
  input  logic [LEVEL_BITS-1:0] ramp_steps,
  input  logic [TIME_BITS-1:0]  step_ticks,
  input  logic [TIME_BITS-1:0]  hold_ticks,
  output logic [LEVEL_BITS-1:0] level,
  output twg_pkg::seg_t         segment,
  output logic                  period_start
);

  twg_pkg::seg_t         seg_r, seg_nxt, seg_eff;
  logic [LEVEL_BITS-1:0] idx_r, idx_nxt, idx_eff, idx_inc, steps;
  logic [TIME_BITS-1:0]  tick_r, tick_nxt, tick_eff, dur, dur_eff;
  logic [TIME_BITS:0]    tick_inc;
  logic [2*LEVEL_BITS-1:0] prod;
  logic [LEVEL_BITS-1:0] ramp_level;
  logic                  step_end;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seg_r  <= twg_pkg::SEG_RISE;
      idx_r  <= '0;
      tick_r <= '0;
    end else if (advance) begin
      seg_r  <= seg_nxt;
      idx_r  <= idx_nxt;
      tick_r <= tick_nxt;
    end
  end

  always_comb begin
    // restart takes effect before this tick is output
    seg_eff  = restart ? twg_pkg::SEG_RISE : seg_r;
    idx_eff  = restart ? '0 : idx_r;
    tick_eff = restart ? '0 : tick_r;

    steps = (ramp_steps == '0) ? LEVEL_BITS'(1) : ramp_steps;

    prod = {{LEVEL_BITS{1'b0}}, idx_eff} * {{LEVEL_BITS{1'b0}}, step_size};
    ramp_level = (prod[2*LEVEL_BITS-1:LEVEL_BITS] != '0) ? '1 : prod[LEVEL_BITS-1:0];

    period_start = (seg_eff == twg_pkg::SEG_RISE) && (idx_eff == '0) && (tick_eff == '0);

    unique case (seg_eff) inside
      twg_pkg::SEG_RISE, twg_pkg::SEG_FALL: begin
        level = ramp_level;
        dur   = step_ticks;
      end
      twg_pkg::SEG_TOP: begin
        level = peak_level;
        dur   = hold_ticks;
      end
      twg_pkg::SEG_LOW: begin
        level = step_size;
        dur   = hold_ticks;
      end
    endcase
    segment = seg_eff;

    dur_eff  = (dur == '0) ? TIME_BITS'(1) : dur;
    tick_inc = {1'b0, tick_eff} + {{TIME_BITS{1'b0}}, 1'b1};
    step_end = (tick_inc >= {1'b0, dur_eff});
    idx_inc  = idx_eff + LEVEL_BITS'(1);

    seg_nxt  = seg_eff;
    idx_nxt  = idx_eff;
    tick_nxt = tick_inc[TIME_BITS-1:0];

    if (step_end) begin
      tick_nxt = '0;
      unique case (seg_eff)
        twg_pkg::SEG_RISE: begin
          idx_nxt = idx_inc;
          // index wrap also ends the ramp
          if ((idx_inc >= steps) || (idx_inc == '0)) begin
            seg_nxt = twg_pkg::SEG_TOP;
          end
        end
        twg_pkg::SEG_TOP: begin
          seg_nxt = twg_pkg::SEG_FALL;
          idx_nxt = steps;
        end
        twg_pkg::SEG_FALL: begin
          if (idx_eff <= LEVEL_BITS'(1)) begin
            idx_nxt = '0;
            seg_nxt = twg_pkg::SEG_LOW;
          end else begin
            idx_nxt = idx_eff - LEVEL_BITS'(1);
          end
        end
        twg_pkg::SEG_LOW: begin
          seg_nxt = twg_pkg::SEG_RISE;
          idx_nxt = '0;
        end
      endcase
    end
  end

endmodule

FILE: sim/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for trapezoid_wave_generator. Timebase ticks are sent
// in bursts while the result side stalls on its own pattern. Each accepted
// tick steps a local model of the segment sequencer, which queues the level,
// segment and period flag due. Each result is compared against that queue.
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int          LEVEL_BITS = 12;
  localparam int          TIME_BITS  = 20;
  localparam logic [11:0] LEVEL_MAX  = 12'hFFF;
  localparam logic [19:0] TIME_MAX   = 20'hFFFFF;

  typedef struct {
    logic [11:0]   level;
    twg_pkg::seg_t segment;
    logic          period_start;
  } wave_sample_t;

  logic              clk        = 1'b0;
  logic              rst_n      = 1'b0;
  logic              cfg_we     = 1'b0;
  twg_pkg::cfg_reg_t cfg_addr   = twg_pkg::REG_PEAK_LEVEL;
  logic [19:0]       cfg_wdata  = '0;
  logic              in_valid   = 1'b0;
  logic              in_restart = 1'b0;
  logic              out_ready  = 1'b0;
  logic              in_ready;
  logic              out_valid;
  logic [11:0]       out_level;
  logic [1:0]        out_segment;
  logic              out_period_start;

  // Model of the register file and sequencer
  logic [11:0]   peak_cfg       = 12'(twg_pkg::RST_PEAK_LEVEL);
  logic [11:0]   step_size_cfg  = 12'(twg_pkg::RST_STEP_SIZE);
  logic [11:0]   ramp_steps_cfg = 12'(twg_pkg::RST_RAMP_STEPS);
  logic [19:0]   step_ticks_cfg = 20'(twg_pkg::RST_STEP_TICKS);
  logic [19:0]   hold_ticks_cfg = 20'(twg_pkg::RST_HOLD_TICKS);
  twg_pkg::seg_t seg_st         = twg_pkg::SEG_RISE;
  logic [11:0]   ramp_idx       = '0;
  logic [19:0]   tick_cnt       = '0;

  wave_sample_t wave_q[$];
  wave_sample_t due_s;

  int fault_count   = 0;
  int ticks_sent    = 0;
  int restarts_sent = 0;
  int settings_used = 0;
  int results_seen  = 0;
  int seg_hits[4]   = '{0, 0, 0, 0};
  int burst_left    = 0;
  bit steady        = 1'b0;

  trapezoid_wave_generator #(
    .LEVEL_BITS(LEVEL_BITS),
    .TIME_BITS (TIME_BITS)
  ) uut (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_we          (cfg_we),
    .cfg_addr        (cfg_addr),
    .cfg_wdata       (cfg_wdata),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_restart      (in_restart),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_level       (out_level),
    .out_segment     (out_segment),
    .out_period_start(out_period_start)
  );

  always #4 clk = ~clk;

  initial begin
    #5_000_000;
    $display("TEST FAILED");
    $finish;
  end

  // Step the sequencer by one tick and return what the block must output
  function automatic wave_sample_t advance_wave(input logic restart);
    wave_sample_t s;
    logic [11:0]  steps;
    logic [23:0]  prod;
    logic [20:0]  dur;
    if (restart) begin
      seg_st   = twg_pkg::SEG_RISE;
      ramp_idx = '0;
      tick_cnt = '0;
    end
    steps = (ramp_steps_cfg == 0) ? 12'd1 : ramp_steps_cfg;
    s.period_start = (seg_st == twg_pkg::SEG_RISE) && (ramp_idx == 0) && (tick_cnt == 0);
    s.segment = seg_st;
    case (seg_st) inside
      twg_pkg::SEG_RISE, twg_pkg::SEG_FALL: begin
        prod = ramp_idx * step_size_cfg;
        s.level = (prod > LEVEL_MAX) ? LEVEL_MAX : prod[11:0];
        dur = (step_ticks_cfg == 0) ? 21'd1 : {1'b0, step_ticks_cfg};
      end
      twg_pkg::SEG_TOP: begin
        s.level = peak_cfg;
        dur = (hold_ticks_cfg == 0) ? 21'd1 : {1'b0, hold_ticks_cfg};
      end
      default: begin
        s.level = step_size_cfg;
        dur = (hold_ticks_cfg == 0) ? 21'd1 : {1'b0, hold_ticks_cfg};
      end
    endcase
    if ({1'b0, tick_cnt} + 21'd1 >= dur) begin
      tick_cnt = '0;
      case (seg_st)
        twg_pkg::SEG_RISE: begin
          ramp_idx = ramp_idx + 12'd1;
          if (ramp_idx >= steps || ramp_idx == 0) seg_st = twg_pkg::SEG_TOP;
        end
        twg_pkg::SEG_TOP: begin
          seg_st   = twg_pkg::SEG_FALL;
          ramp_idx = steps;
        end
        twg_pkg::SEG_FALL: begin
          if (ramp_idx <= 1) begin
            ramp_idx = '0;
            seg_st   = twg_pkg::SEG_LOW;
          end else begin
            ramp_idx = ramp_idx - 12'd1;
          end
        end
        default: begin
          seg_st   = twg_pkg::SEG_RISE;
          ramp_idx = '0;
        end
      endcase
    end else begin
      tick_cnt = tick_cnt + 20'd1;
    end
    return s;
  endfunction

  // Queue the expected sample for every accepted tick
  always @(posedge clk) begin
    if (rst_n && in_valid && in_ready) begin
      wave_q.push_back(advance_wave(in_restart));
      seg_hits[wave_q[$].segment]++;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (wave_q.size() == 0) begin
        $display("%0t: unexpected result level %0d segment %0d period_start %0d",
                 $time, out_level, out_segment, out_period_start);
        fault_count++;
      end else begin
        due_s = wave_q.pop_front();
        results_seen++;
        if (out_level !== due_s.level) begin
          $display("%0t: level expected %0d actual %0d", $time, due_s.level, out_level);
          fault_count++;
        end
        if (out_segment !== due_s.segment) begin
          $display("%0t: segment expected %0d actual %0d",
                   $time, due_s.segment, out_segment);
          fault_count++;
        end
        if (out_period_start !== due_s.period_start) begin
          $display("%0t: period_start expected %0d actual %0d",
                   $time, due_s.period_start, out_period_start);
          fault_count++;
        end
      end
    end
  end

  // Result side back-pressure, in one of four randomly drawn modes
  int rx_cycle = 0;
  int rx_mode  = 0;
  int rx_hold  = 0;

  always @(negedge clk) begin
    rx_cycle++;
    if (rx_cycle % 256 == 0) rx_mode = $urandom_range(0, 3);
    case (rx_mode)
      0: out_ready <= 1'b1;
      1: out_ready <= 1'($urandom_range(0, 1));
      2: out_ready <= (rx_cycle % 5) < 3;
      default: begin
        if (rx_hold > 0) begin
          rx_hold--;
          out_ready <= 1'b0;
        end else begin
          if ($urandom_range(0, 19) == 0) rx_hold = $urandom_range(4, 16);
          out_ready <= 1'b1;
        end
      end
    endcase
  end

  task automatic write_reg(input twg_pkg::cfg_reg_t idx, input logic [19:0] value);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_addr  <= idx;
    cfg_wdata <= value;
    @(negedge clk);
    cfg_we <= 1'b0;
    case (idx)
      twg_pkg::REG_PEAK_LEVEL: peak_cfg       = value[11:0];
      twg_pkg::REG_STEP_SIZE:  step_size_cfg  = value[11:0];
      twg_pkg::REG_RAMP_STEPS: ramp_steps_cfg = value[11:0];
      twg_pkg::REG_STEP_TICKS: step_ticks_cfg = value;
      default:                 hold_ticks_cfg = value;
    endcase
  endtask

  task automatic load_wave(input logic [11:0] peak, input logic [11:0] step,
                           input logic [11:0] ramp, input logic [19:0] st,
                           input logic [19:0] ht);
    write_reg(twg_pkg::REG_PEAK_LEVEL, {8'd0, peak});
    write_reg(twg_pkg::REG_STEP_SIZE, {8'd0, step});
    write_reg(twg_pkg::REG_RAMP_STEPS, {8'd0, ramp});
    write_reg(twg_pkg::REG_STEP_TICKS, st);
    write_reg(twg_pkg::REG_HOLD_TICKS, ht);
    settings_used++;
  endtask

  // Send one tick transaction; unless steady is set, the sender works in bursts with gaps between
  task automatic send_tick(input logic restart);
    int gap;
    if (!steady && burst_left == 0) begin
      gap        = $urandom_range(1, 8);
      burst_left = $urandom_range(1, 24);
      @(negedge clk);
      in_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    if (burst_left > 0) burst_left--;
    @(negedge clk);
    in_valid   <= 1'b1;
    in_restart <= restart;
    do @(posedge clk); while (!in_ready);
    ticks_sent++;
    if (restart) restarts_sent++;
  endtask

  task automatic send_ticks(input int count, input int restart_odds);
    int n;
    for (n = 0; n < count; n++) send_tick($urandom_range(1, restart_odds) == 1);
  endtask

  // Drop valid and hold until every queued sample has come out
  task automatic drain_ticks();
    @(negedge clk);
    in_valid <= 1'b0;
    while (wave_q.size() != 0) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic test_reset_defaults();
    int n;
    for (n = 0; n < 6; n++) send_tick(1'b0);
    send_tick(1'b1);
    drain_ticks();
  endtask

  // Zero durations and zero ramp steps: each segment lasts a single tick
  task automatic test_zero_durations();
    int n;
    load_wave(12'd0, LEVEL_MAX, 12'd0, 20'd0, 20'd0);
    for (n = 0; n < 6; n++) send_tick(1'b0);
    drain_ticks();
  endtask

  task automatic test_level_saturation();
    load_wave(LEVEL_MAX, 12'd2000, 12'd3, 20'd1, 20'd1);
    send_tick(1'b1);
    repeat (7) send_tick(1'b0);
    drain_ticks();
  endtask

  task automatic test_long_durations();
    load_wave(12'hAAA, 12'h555, LEVEL_MAX, TIME_MAX, TIME_MAX);
    repeat (3) send_tick(1'b0);
    send_tick(1'b1);
    send_tick(1'b0);
    drain_ticks();
  endtask

  task automatic test_restart_mid_period();
    int n;
    load_wave(12'd3000, 12'd100, 12'd4, 20'd3, 20'd2);
    send_tick(1'b1);
    for (n = 1; n < 30; n++) send_tick(n == 7 || n == 13 || n == 14 || n == 22);
    drain_ticks();
  endtask

  // Shrink durations and ramp length while the sequencer is mid-step
  task automatic test_config_mid_period();
    load_wave(12'd2500, 12'd50, 12'd10, 20'd6, 20'd4);
    send_tick(1'b1);
    send_ticks(24, 1000);
    drain_ticks();
    write_reg(twg_pkg::REG_STEP_TICKS, 20'd1);
    write_reg(twg_pkg::REG_RAMP_STEPS, 20'd2);
    settings_used++;
    send_ticks(3, 1000);
    drain_ticks();
    write_reg(twg_pkg::REG_RAMP_STEPS, 20'd7);
    write_reg(twg_pkg::REG_HOLD_TICKS, 20'd0);
    settings_used++;
    send_ticks(20, 1000);
    drain_ticks();
  endtask

  task automatic test_random_waves();
    int          round;
    int          odds;
    logic [11:0] peak, step, ramp;
    logic [19:0] st, ht;
    for (round = 0; round < 13; round++) begin
      peak = 12'($urandom_range(0, 4095));
      step = $urandom_range(0, 1) ? 12'($urandom_range(0, 4095))
                                  : 12'($urandom_range(0, 64));
      case ($urandom_range(0, 9))
        0:       ramp = 12'd0;
        1:       ramp = 12'($urandom_range(1, 4095));
        default: ramp = 12'($urandom_range(1, 12));
      endcase
      st = ($urandom_range(0, 11) == 0) ? 20'($urandom_range(0, 20'hFFFFF))
                                        : 20'($urandom_range(0, 4));
      ht = ($urandom_range(0, 11) == 0) ? 20'($urandom_range(0, 20'hFFFFF))
                                        : 20'($urandom_range(0, 6));
      load_wave(peak, step, ramp, st, ht);
      // Mostly whole periods, with a few rounds of frequent restarts
      odds   = ($urandom_range(0, 3) == 0) ? 4 : 300;
      steady = ($urandom_range(0, 3) == 0);
      send_ticks(120, odds);
      steady = 1'b0;
      drain_ticks();
    end
  endtask

  initial begin
    repeat (4) @(negedge clk);
    rst_n <= 1'b1;
    test_reset_defaults();
    test_zero_durations();
    test_level_saturation();
    test_long_durations();
    test_restart_mid_period();
    test_config_mid_period();
    test_random_waves();
    drain_ticks();
    repeat (8) @(posedge clk);
    $display("Ran %0d ticks (%0d with restart) over %0d register settings,",
             ticks_sent, restarts_sent, settings_used);
    $display("%0d results checked; ticks per segment: rising %0d, top %0d, falling %0d, low %0d",
             results_seen, seg_hits[0], seg_hits[1], seg_hits[2], seg_hits[3]);
    if (fault_count == 0 && wave_q.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
